[hdl/matrix_chain_order_cost_core_defines.svh]
// Assertion macros for the matrix chain order cost core.
// Included by the top level; depends on signals named clk and arst_n in scope.
`ifndef MATRIX_CHAIN_ORDER_COST_CORE_DEFINES_SVH
`define MATRIX_CHAIN_ORDER_COST_CORE_DEFINES_SVH

`ifndef SYNTH

// The property holds at every clock edge outside reset.
`define MCOC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("matrix chain cost core: invariant violated");

// When ante holds, cons holds in the next cycle.
`define MCOC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("matrix chain cost core: sequence violated");

`else

`define MCOC_ASSERT(lbl, prop)
`define MCOC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/mcoc_pkg.sv]
// Shared types and constants of the matrix chain order cost core.
// Used by the controller, the datapath and the top level; no dependencies.
package mcoc_pkg;

	localparam int MAX_DIMS_DEF = 16;
	localparam int DIM_BITS_DEF = 16;
	localparam int DIM_IN_W     = 16;
	localparam int COST_W       = 63;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SETUP,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic setup;
		logic issue;
		logic write;
		logic load;
		logic out_load;
		logic out_zero;
		logic out_ovf;
	} cmd_t;

	typedef struct packed {
		logic busy;
	} stat_t;

endpackage

[hdl/mcoc_ctrl.sv]
// Controller of the matrix chain order cost core: chain loading, interval
// sequencing and result hand-off. Depends on mcoc_pkg.
module mcoc_ctrl #(
	parameter int MAX_DIMS = mcoc_pkg::MAX_DIMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	input  mcoc_pkg::stat_t             stat,
	output mcoc_pkg::cmd_t              cmd,
	output logic [$clog2(MAX_DIMS)-1:0] wr_idx,
	output logic [$clog2(MAX_DIMS)-1:0] i_idx,
	output logic [$clog2(MAX_DIMS)-1:0] j_idx,
	output logic [$clog2(MAX_DIMS)-1:0] k_idx
);

	localparam int IDX_W = $clog2(MAX_DIMS);
	localparam int CNT_W = $clog2(MAX_DIMS + 1);

	mcoc_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             ovf_q, ovf_d;
	logic [IDX_W-1:0] top_q, top_d;
	logic [IDX_W-1:0] len_q, len_d;
	logic [IDX_W-1:0] i_q, i_d;
	logic [IDX_W-1:0] k_q, k_d;
	logic             short_q, short_d;
	logic             out_valid_q, out_valid_d;
	logic [IDX_W-1:0] top_new;

	assign j_idx     = i_q + len_q - IDX_W'(1);
	assign i_idx     = i_q;
	assign k_idx     = k_q;
	assign wr_idx    = cnt_q[IDX_W-1:0];
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mcoc_pkg::ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			top_q       <= '0;
			len_q       <= '0;
			i_q         <= '0;
			k_q         <= '0;
			short_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			ovf_q       <= ovf_d;
			top_q       <= top_d;
			len_q       <= len_d;
			i_q         <= i_d;
			k_q         <= k_d;
			short_q     <= short_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		ovf_d       = ovf_q;
		top_d       = top_q;
		len_d       = len_q;
		i_d         = i_q;
		k_d         = k_q;
		short_d     = short_q;
		out_valid_d = out_valid_q && out_stall;
		in_stall    = 1'b1;
		cmd         = '0;
		// Index of the last stored dimension once this item is counted.
		top_new     = (cnt_q < CNT_W'(MAX_DIMS)) ? cnt_q[IDX_W-1:0] : IDX_W'(MAX_DIMS - 1);

		unique case (state_q)
			mcoc_pkg::ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (cnt_q < CNT_W'(MAX_DIMS)) begin
						cmd.load = 1'b1;
						cnt_d    = cnt_q + CNT_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (last) begin
						top_d   = top_new;
						short_d = top_new < IDX_W'(2);
						len_d   = IDX_W'(2);
						i_d     = IDX_W'(1);
						state_d = (top_new < IDX_W'(2)) ? mcoc_pkg::ST_DONE : mcoc_pkg::ST_SETUP;
					end
				end
			end
			mcoc_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				k_d       = i_q;
				state_d   = mcoc_pkg::ST_ISSUE;
			end
			mcoc_pkg::ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (k_q == j_idx - IDX_W'(1)) begin
					state_d = mcoc_pkg::ST_DRAIN;
				end else begin
					k_d = k_q + IDX_W'(1);
				end
			end
			mcoc_pkg::ST_DRAIN: begin
				if (!stat.busy) begin
					cmd.write = 1'b1;
					if (j_idx != top_q) begin
						i_d     = i_q + IDX_W'(1);
						state_d = mcoc_pkg::ST_SETUP;
					end else if (len_q != top_q) begin
						len_d   = len_q + IDX_W'(1);
						i_d     = IDX_W'(1);
						state_d = mcoc_pkg::ST_SETUP;
					end else begin
						// The whole-chain interval was the last one filled.
						state_d = mcoc_pkg::ST_DONE;
					end
				end
			end
			mcoc_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					cmd.out_zero = short_q;
					cmd.out_ovf  = ovf_q;
					out_valid_d  = 1'b1;
					cnt_d        = '0;
					ovf_d        = 1'b0;
					state_d      = mcoc_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = mcoc_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

[hdl/mcoc_dp.sv]
// Datapath of the matrix chain order cost core: dimension and cost memories,
// the split-cost pipeline and the running minimum. Depends on mcoc_pkg.
module mcoc_dp #(
	parameter int MAX_DIMS = mcoc_pkg::MAX_DIMS_DEF,
	parameter int DIM_W    = mcoc_pkg::DIM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcoc_pkg::cmd_t                cmd,
	output mcoc_pkg::stat_t               stat,
	input  logic [DIM_W-1:0]              dim_in,
	input  logic [$clog2(MAX_DIMS)-1:0]   wr_idx,
	input  logic [$clog2(MAX_DIMS)-1:0]   i_idx,
	input  logic [$clog2(MAX_DIMS)-1:0]   j_idx,
	input  logic [$clog2(MAX_DIMS)-1:0]   k_idx,
	output logic [mcoc_pkg::COST_W-1:0]   min_cost,
	output logic                          overflow
);

	localparam int IDX_W  = $clog2(MAX_DIMS);
	localparam int CDEPTH = 1 << (2 * IDX_W);
	localparam int CW     = mcoc_pkg::COST_W;

	logic [DIM_W-1:0] dim_mem [MAX_DIMS];
	logic [CW-1:0]    cost_mem [CDEPTH];

	logic [IDX_W-1:0] kp1;
	logic [IDX_W-1:0] dim_addr_a;

	logic             v_s1, v_s2, v_s3;
	logic             setup_s1;
	logic [CW-1:0]    ca_s1, cb_s1;
	logic             az_s1, bz_s1;
	logic [DIM_W-1:0] dima_s1, dimb_s1;
	logic [DIM_W-1:0] dl_q, dr_q;
	logic [CW-1:0]    csum_s2, csum_s3;
	logic [2*DIM_W-1:0] m1_s2;
	logic [3*DIM_W-1:0] prod_s3;
	logic [CW-1:0]    best_q;
	logic [CW-1:0]    split_cost;
	logic [CW-1:0]    min_cost_q;
	logic             overflow_q;

	function automatic logic [CW-1:0] sat_sum(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? mcoc_pkg::COST_MAX : s[CW-1:0];
	endfunction

	assign kp1        = k_idx + IDX_W'(1);
	assign dim_addr_a = cmd.setup ? (i_idx - IDX_W'(1)) : k_idx;
	assign stat.busy  = v_s1 || v_s2 || v_s3;
	assign split_cost = sat_sum(csum_s3, CW'(prod_s3));
	assign min_cost   = min_cost_q;
	assign overflow   = overflow_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dim_mem[wr_idx] <= dim_in;
		end
		dima_s1 <= dim_mem[dim_addr_a];
		dimb_s1 <= dim_mem[j_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			cost_mem[{i_idx, j_idx}] <= best_q;
		end
		ca_s1 <= cost_mem[{i_idx, k_idx}];
		cb_s1 <= cost_mem[{kp1, j_idx}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			setup_s1 <= 1'b0;
		end else begin
			v_s1     <= cmd.issue;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			setup_s1 <= cmd.setup;
		end
	end

	// Single-matrix intervals are never stored; they read as zero here.
	always_ff @(posedge clk) begin
		az_s1   <= (i_idx == k_idx);
		bz_s1   <= (kp1 == j_idx);
		if (setup_s1) begin
			dl_q <= dima_s1;
			dr_q <= dimb_s1;
		end
		csum_s2 <= sat_sum(az_s1 ? '0 : ca_s1, bz_s1 ? '0 : cb_s1);
		m1_s2   <= (2*DIM_W)'(dl_q) * (2*DIM_W)'(dima_s1);
		csum_s3 <= csum_s2;
		prod_s3 <= (3*DIM_W)'(m1_s2) * (3*DIM_W)'(dr_q);
		if (cmd.setup) begin
			best_q <= mcoc_pkg::COST_MAX;
		end else if (v_s3 && (split_cost < best_q)) begin
			best_q <= split_cost;
		end
		if (cmd.out_load) begin
			min_cost_q <= cmd.out_zero ? '0 : best_q;
			overflow_q <= cmd.out_ovf;
		end
	end

endmodule

[hdl/matrix_chain_order_cost_core.sv]
// Matrix chain order cost core. Dimension values arrive one item per cycle
// while the core is loading; the item with last set closes the chain. Up to
// MAX_DIMS values are kept, further ones are dropped and reported through
// overflow. After the closing item the core stalls its input and fills the
// interval cost table in a cost memory, one split point per cycle through a
// four-stage pipeline (memory read, partial product and cost sum, full
// product, saturating add and minimum). For a chain of n stored values the
// fill covers n(n-1)(n-2)/6 split points in (n-1)(n-2)/2 intervals; chains
// shorter than three values skip the fill and give a cost of zero. One result
// item, saturated at 2^63-1, leaves per chain. No clearing pass is needed
// after reset.
// Depends on mcoc_pkg, mcoc_ctrl, mcoc_dp and the core's assertion macros.
`include "matrix_chain_order_cost_core_defines.svh"

module matrix_chain_order_cost_core #(
	parameter int MAX_DIMS = mcoc_pkg::MAX_DIMS_DEF,
	parameter int DIM_BITS = mcoc_pkg::DIM_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mcoc_pkg::DIM_IN_W-1:0]     dimension,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mcoc_pkg::COST_W-1:0]       min_cost,
	output logic                              overflow
);

	localparam int IDX_W = $clog2(MAX_DIMS);
	localparam int DIM_W = (DIM_BITS < mcoc_pkg::DIM_IN_W) ? DIM_BITS : mcoc_pkg::DIM_IN_W;

	mcoc_pkg::cmd_t   cmd;
	mcoc_pkg::stat_t  stat;
	logic [IDX_W-1:0] wr_idx;
	logic [IDX_W-1:0] i_idx;
	logic [IDX_W-1:0] j_idx;
	logic [IDX_W-1:0] k_idx;

	mcoc_ctrl #(
		.MAX_DIMS (MAX_DIMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd),
		.wr_idx    (wr_idx),
		.i_idx     (i_idx),
		.j_idx     (j_idx),
		.k_idx     (k_idx)
	);

	mcoc_dp #(
		.MAX_DIMS (MAX_DIMS),
		.DIM_W    (DIM_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.dim_in   (dimension[DIM_W-1:0]),
		.wr_idx   (wr_idx),
		.i_idx    (i_idx),
		.j_idx    (j_idx),
		.k_idx    (k_idx),
		.min_cost (min_cost),
		.overflow (overflow)
	);

	// An interval minimum is stored only once its pipeline has drained.
	`MCOC_ASSERT(a_write_after_drain, !(cmd.write && stat.busy))
	// No item is taken while split costs are still in flight.
	`MCOC_ASSERT(a_no_accept_in_fill, !(in_valid && !in_stall && stat.busy))
	// A loaded result is offered in the following cycle.
	`MCOC_ASSERT_NEXT(a_result_offered, cmd.out_load, out_valid)
	// Every interval setup, made with the datapath idle, is followed directly by the issue of its first split point.
	`MCOC_ASSERT_NEXT(a_setup_then_issue, cmd.setup, cmd.issue)

endmodule

[test/matrix_chain_order_cost_core_tb.sv]
// Self-checking testbench for the matrix chain order cost core.
// Drives dimension chains through the valid/stall input, predicts each chain cost and checks the
// result items; depends on mcoc_pkg and matrix_chain_order_cost_core.

typedef struct {
	logic [mcoc_pkg::COST_W-1:0] cost;
	logic                        ovf;
} chain_result_t;

class chain_cost_board;
	logic [63:0]   dims[mcoc_pkg::MAX_DIMS_DEF];
	int            dim_count;
	bit            dropped;
	chain_result_t expected_costs[$];
	int            errors;

	function new();
		dim_count = 0;
		dropped   = 0;
		errors    = 0;
	endfunction

	function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > {1'b0, mcoc_pkg::COST_MAX}) ? {1'b0, mcoc_pkg::COST_MAX} : s;
	endfunction

	// Bottom-up interval fill over matrices 1..n-1.
	function logic [mcoc_pkg::COST_W-1:0] chain_cost(int n);
		logic [63:0] tbl[mcoc_pkg::MAX_DIMS_DEF][mcoc_pkg::MAX_DIMS_DEF];
		logic [63:0] best;
		logic [63:0] prod;
		logic [63:0] c;
		int          j;
		if (n < 3)
			return '0;
		for (int i = 1; i < n; i++)
			tbl[i][i] = '0;
		for (int len = 2; len < n; len++) begin
			for (int i = 1; i + len - 1 < n; i++) begin
				j    = i + len - 1;
				best = {1'b0, mcoc_pkg::COST_MAX};
				for (int k = i; k < j; k++) begin
					prod = dims[i-1] * dims[k] * dims[j];
					c    = sat_add(sat_add(tbl[i][k], tbl[k+1][j]), prod);
					if (c < best)
						best = c;
				end
				tbl[i][j] = best;
			end
		end
		return tbl[1][n-1][mcoc_pkg::COST_W-1:0];
	endfunction

	function void note_dimension(logic [mcoc_pkg::DIM_IN_W-1:0] d, logic l);
		chain_result_t r;
		logic [63:0]   mask;
		mask = (64'd1 << mcoc_pkg::DIM_BITS_DEF) - 64'd1;
		if (dim_count < mcoc_pkg::MAX_DIMS_DEF) begin
			dims[dim_count] = {48'd0, d} & mask;
			dim_count++;
		end else begin
			dropped = 1;
		end
		if (l) begin
			r.cost = chain_cost(dim_count);
			r.ovf  = dropped;
			expected_costs.push_back(r);
			dim_count = 0;
			dropped   = 0;
		end
	endfunction

	function void check_result(logic [mcoc_pkg::COST_W-1:0] c, logic o);
		chain_result_t r;
		if (expected_costs.size() == 0) begin
			$display("%0t: result with no chain pending: min_cost %0d overflow %0b", $time, c, o);
			errors++;
			return;
		end
		r = expected_costs.pop_front();
		if (c !== r.cost) begin
			$display("%0t: min_cost mismatch: expected %0d actual %0d", $time, r.cost, c);
			errors++;
		end
		if (o !== r.ovf) begin
			$display("%0t: overflow mismatch: expected %0b actual %0b", $time, r.ovf, o);
			errors++;
		end
	endfunction

	function int pending();
		return expected_costs.size();
	endfunction
endclass

module matrix_chain_order_cost_core_tb;

	localparam int RAND_ITEMS   = 1350;
	localparam int QUIET_LIMIT  = 20000;
	localparam int FILL_CYCLES  = 1200;
	localparam int HOLD_AT      = 30;
	localparam int HOLD_CYCLES  = 1500;
	localparam int PAUSE_AT     = 700;
	localparam int DIN_W        = mcoc_pkg::DIM_IN_W;
	localparam int MAX_DIMS     = mcoc_pkg::MAX_DIMS_DEF;

	typedef enum int {
		VAL_FULL,
		VAL_SMALL,
		VAL_EXTREME
	} value_style_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [DIN_W-1:0]            dimension;
	logic                        last;
	logic                        out_valid;
	logic                        out_stall;
	logic [mcoc_pkg::COST_W-1:0] min_cost;
	logic                        overflow;

	chain_cost_board board;
	int              quiet_cycles;
	bit              sender_quiet;
	int              sent_items;

	matrix_chain_order_cost_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.dimension (dimension),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.min_cost  (min_cost),
		.overflow  (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Both handshakes are observed here, on the rising edge.
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				board.check_result(min_cost, overflow);
				quiet_cycles = 0;
			end else begin
				quiet_cycles = quiet_cycles + 1;
			end
			if (in_valid && !in_stall) begin
				board.note_dimension(dimension, last);
				quiet_cycles = 0;
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no item accepted for %0d cycles", $time, QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// Result side: random stall before each item, quiet stretches, and one long hold-off.
	initial begin
		int  gap;
		int  results_seen;
		bit  recv_quiet;
		out_stall    = 1'b0;
		results_seen = 0;
		recv_quiet   = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (results_seen == HOLD_AT) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = recv_quiet ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				out_stall = 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall = 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			results_seen++;
			if (results_seen % 16 == 0)
				recv_quiet = ($urandom_range(0, 3) == 0);
			@(negedge clk);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(logic [DIN_W-1:0] d, logic l);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		dimension = d;
		last      = l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic send_chain(int n, value_style_t style);
		logic [DIN_W-1:0] d;
		for (int i = 0; i < n; i++) begin
			case (style)
				VAL_SMALL:   d = DIN_W'($urandom_range(0, 15));
				VAL_EXTREME: d = ($urandom_range(0, 1) == 0) ? '0 : '1;
				default:     d = DIN_W'($urandom());
			endcase
			send_item(d, i == n - 1);
		end
	endtask

	task automatic wait_results_done();
		in_valid = 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int           n;
		int           pick;
		bit           paused;
		value_style_t style;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		dimension    = '0;
		last         = 1'b0;
		sender_quiet = 0;
		sent_items   = 0;
		paused       = 0;
		board        = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: one value, two values, a textbook chain, and a chain past capacity.
		send_item(16'd7, 1'b1);
		send_item(16'd0, 1'b0);
		send_item(16'hFFFF, 1'b1);
		send_item(16'd10, 1'b0);
		send_item(16'd20, 1'b0);
		send_item(16'd30, 1'b0);
		send_item(16'd40, 1'b1);
		for (int i = 0; i < MAX_DIMS + 1; i++)
			send_item(16'hFFFF, i == MAX_DIMS);
		wait_results_done();

		sent_items = 0;
		while (sent_items < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				n = $urandom_range(1, 8);
			else if (pick < 90)
				n = $urandom_range(9, MAX_DIMS);
			else
				n = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 4);
			pick = $urandom_range(0, 9);
			style = (pick < 6) ? VAL_FULL : (pick < 8) ? VAL_SMALL : VAL_EXTREME;
			sender_quiet = ($urandom_range(0, 4) == 0);
			send_chain(n, style);
			if (!paused && sent_items >= PAUSE_AT) begin
				paused = 1;
				wait_results_done();
			end
		end
		in_valid = 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (FILL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
